// File: sv/mmsl_pkg.sv
package mmsl_pkg;

    // Value width as the cells carry it; DATA_BITS only sets the saturation range.
    localparam int DATA_BITS  = 32;
    localparam int SAT_BITS   = (DATA_BITS < 32) ? DATA_BITS : 32;
    localparam int VAL_W      = 32;
    localparam int ALPHA_W    = 16;
    localparam int ALPHA_FRAC = 12;
    // |slope| * alpha >> 12 keeps this many bits.
    localparam int MAG_W      = VAL_W + ALPHA_W - ALPHA_FRAC;
    // 2*diff << 16 over the width sum: the numerator sits 17 bits up.
    localparam int NUM_SHIFT  = 17;
    localparam int DIV_STEPS  = 32;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    // Overflow test: quotient >= 2^DIV_STEPS when mag >= den << PRE_SHIFT.
    localparam int PRE_SHIFT  = DIV_STEPS - NUM_SHIFT;

    localparam logic [15:0] ALPHA_RESET = 16'd4096;

    typedef enum logic {
        CFG_LIMIT_MODE = 1'b0,
        CFG_ALPHA_GAIN = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        FILL_IDLE  = 2'd0,
        FILL_GHOST = 2'd1,
        FILL_HELD  = 2'd2
    } t_fill;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_FIX,
        ST_POST,
        ST_SCALE_L,
        ST_SCALE_R,
        ST_LIMIT
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] cell_value;
        logic [VAL_W-1:0]        cell_width;
        logic signed [VAL_W-1:0] old_slope;
        logic                    first_cell;
        logic                    last_cell;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] slope;
        logic                    run_end;
    } t_out_item;

endpackage

// File: sv/minmod_slope_limiter_unit.sv
// Each divided difference is formed by a 32-step restoring radix-2 divider; the divider is
// skipped when the difference is zero or the quotient saturates. Bound mode adds two alpha
// scaling states. The input stalls until the current item is finished, so the unit takes no
// new item while busy. The first real cell of a run is divided but gives no result; start,
// ignored and empty-run items are taken in the idle state without entering the sequencer.
// Reset (synchronous, active low) clears the sequencer, run fill and output valid, sets
// limit_mode to 0 and alpha_gain to 4096.
module minmod_slope_limiter_unit
    import mmsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    function automatic logic [VAL_W-1:0] abs_val(input logic signed [VAL_W-1:0] s);
        return s[VAL_W-1] ? (~s + VAL_W'(1)) : s;
    endfunction

    // Signed saturation of a sign and magnitude to SAT_BITS, sign-extended to VAL_W.
    function automatic logic [VAL_W-1:0] sat_mag(input logic neg,
                                                 input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] val;
        lim = MAG_W'(1) << (SAT_BITS - 1);
        if (!neg && mag >= lim)
            val = lim - MAG_W'(1);
        else if (neg && mag > lim)
            val = -lim;
        else
            val = neg ? -mag : mag;
        return val[VAL_W-1:0];
    endfunction

    t_state                  r_state, n_state;
    t_fill                   r_fill;
    logic                    r_limit_mode;
    logic [ALPHA_W-1:0]      r_alpha_gain;
    logic                    r_out_valid;
    t_out_item               r_out_item;

    logic signed [VAL_W-1:0] r_prev_value;
    logic [VAL_W-1:0]        r_prev_width;
    logic signed [VAL_W-1:0] r_left_slope;
    logic signed [VAL_W-1:0] r_held_old;
    t_in_item                r_cur;

    logic                    r_neg;
    logic [VAL_W:0]          r_mag;
    logic [VAL_W:0]          r_den;
    logic [VAL_W:0]          r_rem;
    logic [VAL_W-1:0]        r_num;
    logic [DIV_STEPS-1:0]    r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [VAL_W-1:0] r_d;
    logic                    r_sa, r_sb;
    logic [MAG_W-1:0]        r_ma, r_mb;

    logic                    s_in_stall;
    logic                    in_xfer;
    logic                    out_free;
    logic signed [VAL_W:0]   diff;
    logic                    ovf;
    logic [VAL_W+1:0]        trial;
    logic                    ge;
    logic [VAL_W+1:0]        trial_sub;
    logic [VAL_W:0]          rem_next;
    logic [VAL_W-1:0]        mul_in;
    logic [VAL_W+ALPHA_W-1:0] prod;
    logic [MAG_W-1:0]        mc;
    logic                    c_neg;
    logic                    a_nz, b_nz, c_nz;
    logic                    all_pos, all_neg;
    logic [MAG_W-1:0]        mab, mres;
    logic [VAL_W-1:0]        slope;

    assign in_xfer  = i_in_valid && !s_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Divided-difference front end.
    assign diff = {r_cur.cell_value[VAL_W-1], r_cur.cell_value}
                - {r_prev_value[VAL_W-1], r_prev_value};
    assign ovf  = {(VAL_W+PRE_SHIFT)'(r_mag)} >= {r_den, PRE_SHIFT'(0)};

    // One restoring step per cycle.
    assign trial     = {r_rem, r_num[VAL_W-1]};
    assign ge        = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};
    assign rem_next  = ge ? trial_sub[VAL_W:0] : trial[VAL_W:0];

    // Shared alpha multiplier for both scaled slopes.
    assign mul_in = (r_state == ST_SCALE_L) ? r_ma[VAL_W-1:0] : r_mb[VAL_W-1:0];
    assign prod   = mul_in * r_alpha_gain;

    // Minmod over sign and magnitude; the third argument counts in bound mode only.
    assign c_neg   = r_held_old[VAL_W-1];
    assign mc      = MAG_W'(abs_val(r_held_old));
    assign a_nz    = r_ma != '0;
    assign b_nz    = r_mb != '0;
    assign c_nz    = mc != '0;
    assign all_pos = !r_sa && a_nz && !r_sb && b_nz && (!r_limit_mode || (!c_neg && c_nz));
    assign all_neg = r_sa && a_nz && r_sb && b_nz && (!r_limit_mode || (c_neg && c_nz));
    assign mab     = (r_ma < r_mb) ? r_ma : r_mb;
    assign mres    = (r_limit_mode && mc < mab) ? mc : mab;
    assign slope   = sat_mag(all_neg, (all_pos || all_neg) ? mres : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        s_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                s_in_stall = 1'b0;
                if (in_xfer && !i_in_item.first_cell && r_fill != FILL_IDLE
                    && !(r_fill == FILL_GHOST && i_in_item.last_cell)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP:  n_state = ST_CHECK;
            ST_CHECK: n_state = (r_mag == '0 || ovf) ? ST_POST : ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1))
                    n_state = ST_FIX;
            end
            ST_FIX: n_state = ST_POST;
            ST_POST: begin
                if (r_fill == FILL_GHOST)
                    n_state = ST_IDLE;
                else
                    n_state = r_limit_mode ? ST_SCALE_L : ST_LIMIT;
            end
            ST_SCALE_L: n_state = ST_SCALE_R;
            ST_SCALE_R: n_state = ST_LIMIT;
            ST_LIMIT: begin
                if (out_free)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= FILL_IDLE;
            r_limit_mode <= 1'b0;
            r_alpha_gain <= ALPHA_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_LIMIT_MODE: r_limit_mode <= i_cfg_data[0];
                    CFG_ALPHA_GAIN: r_alpha_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_IDLE && in_xfer) begin
                if (i_in_item.first_cell)
                    r_fill <= FILL_GHOST;
                else if (r_fill == FILL_GHOST && i_in_item.last_cell)
                    r_fill <= FILL_IDLE;
            end else if (r_state == ST_POST && r_fill == FILL_GHOST) begin
                r_fill <= FILL_HELD;
            end else if (r_state == ST_LIMIT && out_free && r_cur.last_cell) begin
                r_fill <= FILL_IDLE;
            end
            if (r_state == ST_LIMIT && out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_cur <= i_in_item;
                    if (i_in_item.first_cell) begin
                        r_prev_value <= i_in_item.cell_value;
                        r_prev_width <= i_in_item.cell_width;
                    end
                end
            end
            ST_PREP: begin
                r_neg <= diff[VAL_W];
                r_mag <= diff[VAL_W] ? -diff : diff;
                r_den <= {1'b0, r_prev_width} + {1'b0, r_cur.cell_width};
            end
            ST_CHECK: begin
                // Zero difference gives zero; an oversized quotient (or zero width) saturates.
                if (r_mag == '0)
                    r_d <= '0;
                else if (ovf)
                    r_d <= sat_mag(r_neg, '1);
                r_rem <= (VAL_W+1)'(r_mag[VAL_W:PRE_SHIFT]);
                r_num <= {r_mag[PRE_SHIFT-1:0], NUM_SHIFT'(0)};
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= rem_next;
                r_num <= r_num << 1;
                r_quo <= {r_quo[DIV_STEPS-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_FIX: begin
                r_d <= sat_mag(r_neg, MAG_W'(r_quo));
            end
            ST_POST: begin
                if (r_fill == FILL_GHOST) begin
                    r_left_slope <= r_d;
                    r_held_old   <= r_cur.old_slope;
                    r_prev_value <= r_cur.cell_value;
                    r_prev_width <= r_cur.cell_width;
                end else begin
                    r_sa <= r_left_slope[VAL_W-1];
                    r_ma <= MAG_W'(abs_val(r_left_slope));
                    r_sb <= r_d[VAL_W-1];
                    r_mb <= MAG_W'(abs_val(r_d));
                end
            end
            ST_SCALE_L: r_ma <= prod[VAL_W+ALPHA_W-1:ALPHA_FRAC];
            ST_SCALE_R: r_mb <= prod[VAL_W+ALPHA_W-1:ALPHA_FRAC];
            ST_LIMIT: begin
                if (out_free) begin
                    r_out_item.slope   <= slope;
                    r_out_item.run_end <= r_cur.last_cell;
                    // Advance the window unless the run ends here.
                    if (!r_cur.last_cell) begin
                        r_left_slope <= r_d;
                        r_held_old   <= r_cur.old_slope;
                        r_prev_value <= r_cur.cell_value;
                        r_prev_width <= r_cur.cell_width;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = s_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: sv/mmsl_checker.sv
module mmsl_checker
    import mmsl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // A result appears only at the end of a busy period.
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without busy sequencer");

    // Busy starts only on an input transfer.
    a_busy_from_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("stall raised without an input transfer");

endmodule

bind minmod_slope_limiter_unit mmsl_checker u_mmsl_checker (.*);

// File: verif/minmod_slope_limiter_unit_tb.sv
`timescale 1ns / 100ps

module minmod_slope_limiter_unit_tb;
    import mmsl_pkg::*;

    localparam logic MODE_PLAIN    = 1'b0;
    localparam logic MODE_BOUND    = 1'b1;
    localparam int   SETTLE_CYCLES = 60;
    localparam int   STALL_LIMIT   = 4000;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   PHASE_CELLS   = 140;

    // Predicts the limited slope of each held cell and checks the block against it.
    class slope_board;
        logic              bound_mode;
        logic [15:0]       gain;
        t_fill             fill;
        logic signed [31:0] prev_val;
        logic [31:0]       prev_wid;
        longint            left_d;
        logic signed [31:0] held_os;
        t_out_item         pending_slopes[$];
        int                fails;

        function new();
            bound_mode = MODE_PLAIN;
            gain       = ALPHA_RESET;
            fill       = FILL_IDLE;
            prev_val   = '0;
            prev_wid   = '0;
            left_d     = 0;
            held_os    = '0;
            fails      = 0;
        endfunction

        function longint clamp(longint v);
            longint lim;
            lim = longint'(1) <<< (SAT_BITS - 1);
            if (v > lim - 1) return lim - 1;
            if (v < -lim) return -lim;
            return v;
        endfunction

        // Divided difference over half the width sum, truncated toward zero.
        function longint diff_slope(logic signed [31:0] vp, logic [31:0] wp,
                                    logic signed [31:0] vc, logic [31:0] wc);
            longint     diff, q;
            logic [63:0] den, mag;
            diff = longint'(vc) - longint'(vp);
            den  = {32'd0, wp} + {32'd0, wc};
            mag  = (diff < 0) ? -diff : diff;
            if (den == 0)
                q = (mag != 0) ? (longint'(1) <<< 40) : 0;
            else
                q = longint'((mag << NUM_SHIFT) / den);
            return clamp((diff < 0) ? -q : q);
        endfunction

        function longint scale(longint s);
            logic [63:0] mag;
            longint      p;
            mag = (s < 0) ? -s : s;
            p   = longint'((mag * {48'd0, gain}) >> ALPHA_FRAC);
            return (s < 0) ? -p : p;
        endfunction

        function longint minmod2(longint a, longint b);
            if (a > 0 && b > 0) return (a < b) ? a : b;
            if (a < 0 && b < 0) return (a > b) ? a : b;
            return 0;
        endfunction

        function longint minmod3(longint a, longint b, longint c);
            if ((a > 0 && b > 0 && c > 0) || (a < 0 && b < 0 && c < 0))
                return minmod2(minmod2(a, b), c);
            return 0;
        endfunction

        function void take_cell(t_in_item it);
            longint    d, res;
            t_out_item o;
            if (it.first_cell) begin
                prev_val = it.cell_value;
                prev_wid = it.cell_width;
                fill     = FILL_GHOST;
                return;
            end
            if (fill == FILL_IDLE) return;
            d = diff_slope(prev_val, prev_wid, it.cell_value, it.cell_width);
            if (fill == FILL_GHOST) begin
                if (it.last_cell) begin
                    fill = FILL_IDLE;
                    return;
                end
                left_d   = d;
                held_os  = it.old_slope;
                prev_val = it.cell_value;
                prev_wid = it.cell_width;
                fill     = FILL_HELD;
                return;
            end
            if (bound_mode == MODE_BOUND)
                res = minmod3(scale(left_d), scale(d), longint'(held_os));
            else
                res = minmod2(left_d, d);
            res       = clamp(res);
            o.slope   = res[31:0];
            o.run_end = it.last_cell;
            pending_slopes.push_back(o);
            if (it.last_cell) begin
                fill = FILL_IDLE;
            end else begin
                left_d   = d;
                held_os  = it.old_slope;
                prev_val = it.cell_value;
                prev_wid = it.cell_width;
            end
        endfunction

        task report(string msg);
            fails++;
            if (fails <= 40) $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task match_slope(t_out_item got);
            t_out_item want;
            if (pending_slopes.size() == 0) begin
                report($sformatf("unexpected slope %h run_end %b", got.slope, got.run_end));
                return;
            end
            want = pending_slopes.pop_front();
            if (got.slope !== want.slope)
                report($sformatf("slope %h, want %h", got.slope, want.slope));
            if (got.run_end !== want.run_end)
                report($sformatf("run_end %b, want %b", got.run_end, want.run_end));
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    logic       cfg_we    = 1'b0;
    t_cfg_index cfg_index = CFG_LIMIT_MODE;
    logic [15:0] cfg_data = '0;

    slope_board sb = new();
    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    minmod_slope_limiter_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic t_in_item make_cell(input logic [31:0] v, w, os, input logic f, l);
        t_in_item it;
        it.cell_value = v;
        it.cell_width = w;
        it.old_slope  = os;
        it.first_cell = f;
        it.last_cell  = l;
        return it;
    endfunction

    function automatic logic [31:0] pick_width(input int style, input logic [31:0] wu);
        logic [31:0] w;
        case (style)
            0:       w = wu;
            1:       w = $urandom_range(1, 32'h40000);
            2:       w = $urandom;
            default: w = $urandom_range(1, 64);
        endcase
        if (w == 0) w = 1;
        return w;
    endfunction

    function automatic logic [31:0] pick_old(input logic signed [31:0] step);
        logic [31:0] mag;
        mag = $urandom_range(0, 32'h3ffff);
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2, 3:    return mag - 32'h1ffff;
            default: return (step < 0) ? -mag : mag;
        endcase
    endfunction

    // Offer one cell, idling at random first; hold it until the transfer.
    task send_cell(input t_in_item it);
        while (!calm && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.take_cell(it);
    endtask

    // Drop valid and drain, then give the block time to finish a silent item.
    task settle();
        in_valid <= 1'b0;
        while (sb.pending_slopes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task set_limits(input logic mode, input logic [15:0] alpha);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LIMIT_MODE;
        cfg_data  <= {15'd0, mode};
        @(posedge clk);
        cfg_index <= CFG_ALPHA_GAIN;
        cfg_data  <= alpha;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        sb.bound_mode = mode;
        sb.gain       = alpha;
    endtask

    task directed_cells();
        // stray cell while idle, then start flag beating last flag, then an empty run
        send_cell(make_cell(32'sd5, 32'h1, 32'sd0, 1'b0, 1'b1));
        send_cell(make_cell(32'sd0, 32'h10000, 32'sd0, 1'b1, 1'b1));
        send_cell(make_cell(32'h10000, 32'h10000, 32'sd0, 1'b0, 1'b1));
        // zero width sums: saturated, flat and falling differences
        send_cell(make_cell(32'sd0, 32'h0, 32'sd7, 1'b1, 1'b0));
        send_cell(make_cell(32'sd100, 32'h0, 32'sd0, 1'b0, 1'b0));
        send_cell(make_cell(32'sd200, 32'h0, 32'sd0, 1'b0, 1'b0));
        send_cell(make_cell(32'sd200, 32'h0, 32'sd0, 1'b0, 1'b0));
        send_cell(make_cell(32'sd100, 32'h0, 32'sd0, 1'b0, 1'b0));
        send_cell(make_cell(32'sd0, 32'h0, 32'sd0, 1'b0, 1'b1));
        // value and width extremes
        send_cell(make_cell(32'h80000000, 32'h1, 32'h7fffffff, 1'b1, 1'b0));
        send_cell(make_cell(32'h7fffffff, 32'h1, 32'h80000000, 1'b0, 1'b0));
        send_cell(make_cell(32'h7fffffff, 32'hffffffff, 32'h7fffffff, 1'b0, 1'b0));
        send_cell(make_cell(32'h80000000, 32'hffffffff, 32'h80000000, 1'b0, 1'b0));
        send_cell(make_cell(32'h80000000, 32'hffffffff, 32'h0, 1'b0, 1'b1));
        // restart in the middle of a run, then rising and falling slopes
        send_cell(make_cell(32'sd0, 32'h10000, 32'sd0, 1'b1, 1'b0));
        send_cell(make_cell(32'h10000, 32'h10000, 32'h10000, 1'b0, 1'b0));
        send_cell(make_cell(32'h30000, 32'h10000, 32'h10000, 1'b0, 1'b0));
        send_cell(make_cell(32'ha0000, 32'h10000, 32'h0, 1'b1, 1'b0));
        send_cell(make_cell(32'h90000, 32'h8000, -32'sh8000, 1'b0, 1'b0));
        send_cell(make_cell(32'h70000, 32'h18000, -32'sh20000, 1'b0, 1'b0));
        send_cell(make_cell(32'h60000, 32'h10000, 32'h0, 1'b0, 1'b1));
    endtask

    task random_runs(input int target);
        int sent, kind, len, vstyle, wstyle, i, n;
        logic signed [31:0] v, step;
        logic [31:0] wu;
        bit broken;
        sent = 0;
        while (sent < target) begin
            kind   = $urandom_range(99);
            len    = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            vstyle = $urandom_range(2);
            wstyle = $urandom_range(3);
            v      = (vstyle == 0) ? $urandom : $urandom_range(0, 32'h3fffff) - 32'h1fffff;
            step   = $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            wu     = $urandom_range(32'h1000, 32'h40000);
            if (kind < 6) begin
                send_cell(make_cell(v, pick_width(wstyle, wu), $urandom, 1'b1, 1'b0));
                send_cell(make_cell($urandom, pick_width(wstyle, wu), $urandom, 1'b0, 1'b1));
                sent += 2;
            end else if (kind < 10) begin
                send_cell(make_cell(v, pick_width(wstyle, wu), $urandom, 1'b1, 1'b1));
                sent += 1;
            end else begin
                broken = (kind < 16);
                send_cell(make_cell(v, pick_width(wstyle, wu), $urandom, 1'b1, 1'b0));
                for (i = 0; i < len; i++) begin
                    case (vstyle)
                        0: v = $urandom;
                        1: begin
                            if ($urandom_range(7) == 0) step = -step;
                            v = v + step + ($urandom_range(0, 2047) - 1024);
                        end
                        default: v = v + ($urandom_range(0, 32'h3fffff) - 32'h1fffff);
                    endcase
                    send_cell(make_cell(v, pick_width(wstyle, wu), pick_old(step), 1'b0, 1'b0));
                end
                sent += len + 1;
                if (!broken) begin
                    v = v + step;
                    send_cell(make_cell(v, pick_width(wstyle, wu), $urandom, 1'b0, 1'b1));
                    sent += 1;
                    // stray cells between runs; the block drops them
                    if ($urandom_range(4) == 0) begin
                        n = $urandom_range(1, 2);
                        repeat (n)
                            send_cell(make_cell($urandom, $urandom, $urandom, 1'b0,
                                                1'($urandom_range(1))));
                    end
                end
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) sb.match_slope(out_item);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 13);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t timeout: no transfer for %0d cycles", $realtime, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : main
        int        ph;
        t_out_item lost;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                1: set_limits(MODE_BOUND, ALPHA_RESET);
                2: set_limits(MODE_BOUND, 16'hffff);
                3: set_limits(MODE_BOUND, 16'h0000);
                4: set_limits(MODE_BOUND, 16'($urandom_range(65535)));
                5: set_limits(MODE_PLAIN, 16'($urandom_range(65535)));
                default: ;
            endcase
            calm = (ph == 2);
            if (ph == 0) directed_cells();
            if (ph == 1) hold_req = 1'b1;
            random_runs(PHASE_CELLS);
            settle();
        end
        while (sb.pending_slopes.size() != 0) begin
            lost = sb.pending_slopes.pop_front();
            sb.report($sformatf("slope %h never arrived", lost.slope));
        end
        if (sb.fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
